[hw/rtl/lqfh_pkg.sv]
// Shared types and constants for the link quality filter with hysteresis.
`default_nettype none

package lqfh_pkg;

    // Field widths
    localparam int MAG_W      = 8;
    localparam int AVG_W      = 9;
    localparam int SAMPLE_W   = 10;
    localparam int WEIGHT_W   = 9;
    localparam int THRESH_W   = 10;

    // Stream word widths
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 1;

    // APB
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    // Register map indexes (byte address = 4 * index)
    localparam reg_idx_t REG_FILTER_WEIGHT    = 3'd0;
    localparam reg_idx_t REG_SNR_LOW          = 3'd1;
    localparam reg_idx_t REG_SNR_HIGH         = 3'd2;
    localparam reg_idx_t REG_STRENGTH_LOW     = 3'd3;
    localparam reg_idx_t REG_STRENGTH_HIGH    = 3'd4;

    // Reset values
    localparam logic [WEIGHT_W-1:0]        RST_FILTER_WEIGHT = 9'd64;
    localparam logic signed [THRESH_W-1:0] RST_SNR_LOW       = -10'sd10;
    localparam logic signed [THRESH_W-1:0] RST_SNR_HIGH      = -10'sd5;
    localparam logic signed [THRESH_W-1:0] RST_STRENGTH_LOW  = -10'sd130;
    localparam logic signed [THRESH_W-1:0] RST_STRENGTH_HIGH = -10'sd125;

endpackage : lqfh_pkg

`default_nettype wire

[hw/rtl/link_quality_filter_hysteresis_unit.sv]
// Top level: link quality lag filter with dual-threshold hysteresis stop flag.
// Usage:
//   s_* stream: one status report word per handshake (strength and noise
//   magnitude bytes). m_* stream: one result word per report, carrying the
//   filtered strength, filtered SNR and, in m_tuser, the link stop flag.
//   APB port: five registers at byte addresses 0x00..0x10 (filter weight,
//   SNR low/high, strength low/high thresholds). Write only while idle.
// Timing:
//   A report is captured in an input register; the lag filter and
//   comparator then load the filter state, which doubles as the output
//   register, and m_tvalid rises as it is loaded. Throughput is one word
//   per cycle while m_tready is high: the filter recurrence (one multiply
//   and add per average) closes in the single stage between the registers.
// Reset:
//   rst_n clears both averages, the primed flag and the stop flag, and
//   loads register defaults. The first report after reset loads the
//   averages directly; later reports are filtered.
// Stall:
//   While m_tready is low a finished word holds on m_*; one more report is
//   still taken into the input register, then s_tready drops.
`default_nettype none

module link_quality_filter_hysteresis_unit #(
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // slave stream: [7:0] strength_magnitude, [15:8] noise_magnitude
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [lqfh_pkg::S_TDATA_W-1:0]       s_tdata,
    // master stream: [8:0] filtered_strength, [17:9] filtered_snr, rest zero
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [lqfh_pkg::M_TDATA_W-1:0]       m_tdata,
    // master tuser: [0] link_stop
    output logic [lqfh_pkg::M_TUSER_W-1:0]       m_tuser,
    // APB configuration port
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [lqfh_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire  [lqfh_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lqfh_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    import lqfh_pkg::*;

    // Clamped weight must hold the value ONE as well as any 9-bit register value
    localparam int EW = (WEIGHT_FRAC_BITS + 1 > WEIGHT_W) ? WEIGHT_FRAC_BITS + 1 : WEIGHT_W;
    localparam logic [EW-1:0] W_ONE = EW'(1) << WEIGHT_FRAC_BITS;
    // Accumulator: old*ONE + diff*w, diff is 11 bits signed
    localparam int AW = SAMPLE_W + 1 + EW + 2;
    localparam logic [AW-1:0] TRUNC_BIAS = (AW'(1) << WEIGHT_FRAC_BITS) - AW'(1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [WEIGHT_W-1:0]        filter_weight_reg;
    logic signed [THRESH_W-1:0] snr_low_reg;
    logic signed [THRESH_W-1:0] snr_high_reg;
    logic signed [THRESH_W-1:0] strength_low_reg;
    logic signed [THRESH_W-1:0] strength_high_reg;

    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_weight_reg <= RST_FILTER_WEIGHT;
            snr_low_reg       <= RST_SNR_LOW;
            snr_high_reg      <= RST_SNR_HIGH;
            strength_low_reg  <= RST_STRENGTH_LOW;
            strength_high_reg <= RST_STRENGTH_HIGH;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_FILTER_WEIGHT: filter_weight_reg <= pwdata[WEIGHT_W-1:0];
                REG_SNR_LOW:       snr_low_reg       <= $signed(pwdata[THRESH_W-1:0]);
                REG_SNR_HIGH:      snr_high_reg      <= $signed(pwdata[THRESH_W-1:0]);
                REG_STRENGTH_LOW:  strength_low_reg  <= $signed(pwdata[THRESH_W-1:0]);
                REG_STRENGTH_HIGH: strength_high_reg <= $signed(pwdata[THRESH_W-1:0]);
                default:           ;
            endcase
        end
    end

    // Read back: weight zero-extended, thresholds sign-extended
    always_comb
    begin
        case (cfg_idx)
            REG_FILTER_WEIGHT: prdata = APB_DATA_W'(filter_weight_reg);
            REG_SNR_LOW:       prdata = APB_DATA_W'(snr_low_reg);
            REG_SNR_HIGH:      prdata = APB_DATA_W'(snr_high_reg);
            REG_STRENGTH_LOW:  prdata = APB_DATA_W'(strength_low_reg);
            REG_STRENGTH_HIGH: prdata = APB_DATA_W'(strength_high_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic             in_valid_reg;
    logic [MAG_W-1:0] strength_mag_reg;
    logic [MAG_W-1:0] noise_mag_reg;
    logic             advance;

    logic             out_valid_reg;
    logic             primed_reg;
    logic             stop_reg;
    logic signed [AVG_W-1:0] strength_avg_reg;
    logic signed [AVG_W-1:0] snr_avg_reg;

    // Word moves from input register into the filter state / output register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            strength_mag_reg <= s_tdata[MAG_W-1:0];
            noise_mag_reg    <= s_tdata[2*MAG_W-1:MAG_W];
        end
    end

    // ---------------------------------------------------------------
    // Lag filter: (old*(ONE-w) + x*w)/ONE == (old*ONE + (x-old)*w)/ONE,
    // divided with truncation toward zero.
    // ---------------------------------------------------------------
    function automatic logic signed [AVG_W-1:0] lag_mix(
        input logic signed [AVG_W-1:0]    old_val,
        input logic signed [SAMPLE_W-1:0] sample,
        input logic [EW-1:0]              w
    );
        logic signed [SAMPLE_W:0] diff;
        logic signed [AW-1:0]     acc;
        logic signed [AW-1:0]     bias;
        logic signed [AW-1:0]     quot;
        diff = (SAMPLE_W+1)'(sample) - (SAMPLE_W+1)'(old_val);
        acc  = (AW'(old_val) <<< WEIGHT_FRAC_BITS) + AW'(diff) * AW'($signed({1'b0, w}));
        bias = acc[AW-1] ? $signed(TRUNC_BIAS) : '0;
        quot = (acc + bias) >>> WEIGHT_FRAC_BITS;
        return quot[AVG_W-1:0];
    endfunction

    logic [EW-1:0]              weight_ext;
    logic [EW-1:0]              weight_eff;
    logic signed [SAMPLE_W-1:0] strength_sample;
    logic signed [SAMPLE_W-1:0] snr_sample;

    logic signed [AVG_W-1:0] strength_avg_next;
    logic signed [AVG_W-1:0] snr_avg_next;
    logic                    stop_next;
    logic signed [THRESH_W-1:0] strength_cmp;
    logic signed [THRESH_W-1:0] snr_cmp;

    assign weight_ext      = EW'(filter_weight_reg);
    assign weight_eff      = (weight_ext > W_ONE) ? W_ONE : weight_ext;
    assign strength_sample = -$signed({2'b00, strength_mag_reg});
    assign snr_sample      = $signed({2'b00, noise_mag_reg}) - $signed({2'b00, strength_mag_reg});

    always_comb
    begin
        if (primed_reg)
        begin
            strength_avg_next = lag_mix(strength_avg_reg, strength_sample, weight_eff);
            snr_avg_next      = lag_mix(snr_avg_reg, snr_sample, weight_eff);
        end
        else
        begin
            // first report after reset loads directly
            strength_avg_next = strength_sample[AVG_W-1:0];
            snr_avg_next      = snr_sample[AVG_W-1:0];
        end

        strength_cmp = THRESH_W'(strength_avg_next);
        snr_cmp      = THRESH_W'(snr_avg_next);

        // Hysteresis: either below low sets, both above high clears, else hold
        if (snr_cmp < snr_low_reg || strength_cmp < strength_low_reg)
            stop_next = 1'b1;
        else if (snr_cmp > snr_high_reg && strength_cmp > strength_high_reg)
            stop_next = 1'b0;
        else
            stop_next = stop_reg;
    end

    // ---------------------------------------------------------------
    // Filter state; also the output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            primed_reg       <= 1'b0;
            stop_reg         <= 1'b0;
            strength_avg_reg <= '0;
            snr_avg_reg      <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                primed_reg       <= 1'b1;
                stop_reg         <= stop_next;
                strength_avg_reg <= strength_avg_next;
                snr_avg_reg      <= snr_avg_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 2*AVG_W)'(0), snr_avg_reg, strength_avg_reg};
    assign m_tuser  = stop_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_out_implies_primed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> primed_reg)
        else $error("result shown before filter primed");

    a_strength_nonpositive: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |-> (strength_avg_reg[AVG_W-1] || strength_avg_reg == '0))
        else $error("filtered strength left its range");

    a_zero_weight_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && primed_reg && filter_weight_reg == '0
        |=> $stable(strength_avg_reg) && $stable(snr_avg_reg))
        else $error("zero weight changed the averages");

endmodule : link_quality_filter_hysteresis_unit

`default_nettype wire
